>>> hdl/utfd_pkg.sv
package utfd_pkg;

  // Replacement character for bad or truncated leads
  localparam logic [20:0] REPL_CP = 21'h00FFFD;

  // Lead length codes: following bytes needed, or a bad lead
  localparam logic [2:0] LEN_ONE  = 3'd0;
  localparam logic [2:0] LEN_BAD  = 3'd4;

  localparam int unsigned MAX_RES = 3;

  // Results caused by one input byte, in order
  typedef struct packed {
    logic [1:0]             cnt;
    logic [2:0][20:0]       cp;
  } bundle_t;

  // Decoder state visible to the top level
  typedef struct packed {
    logic [1:0] pend_cnt;
    logic [1:0] need_len;
  } dec_status_t;

  function automatic logic [2:0] lead_len(logic [7:0] b);
    logic [2:0] len;
    if (!b[7]) begin
      len = LEN_ONE;
    end else if (b[7:5] == 3'b110) begin
      len = 3'd1;
    end else if (b[7:4] == 4'b1110) begin
      len = 3'd2;
    end else if (b[7:3] == 5'b11110) begin
      len = 3'd3;
    end else begin
      len = LEN_BAD;
    end
    return len;
  endfunction

  // Code point of a byte that stands alone (no following bytes)
  function automatic logic [20:0] single_cp(logic [7:0] b);
    return b[7] ? REPL_CP : {13'd0, b};
  endfunction

  function automatic logic [20:0] pack2(logic [7:0] b0, logic [7:0] b1);
    return {10'd0, b0[4:0], b1[5:0]};
  endfunction

  function automatic logic [20:0] pack3(logic [7:0] b0, logic [7:0] b1,
                                        logic [7:0] b2);
    return {5'd0, b0[3:0], b1[5:0], b2[5:0]};
  endfunction

  function automatic logic [20:0] pack4(logic [7:0] b0, logic [7:0] b1,
                                        logic [7:0] b2, logic [7:0] b3);
    return {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
  endfunction

endpackage

>>> hdl/utfd_decode.sv
module utfd_decode import utfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  byte_i,
  input  logic        eot_i,
  input  logic        commit_i,
  output bundle_t     bundle_o,
  output dec_status_t status_o
);

  logic [2:0][7:0] pend_q;
  logic [1:0]      pc_q, pc_d;
  logic [1:0]      nl_q, nl_d;
  logic            store;
  logic [2:0]      len_c;
  logic [2:0]      len_p1;
  logic [20:0]     packed_cp;

  assign len_c  = lead_len(byte_i);
  assign len_p1 = lead_len(pend_q[1]);

  // Completed sequence for the current fill level
  always_comb begin
    case (pc_q)
      2'd1:    packed_cp = pack2(pend_q[0], byte_i);
      2'd2:    packed_cp = pack3(pend_q[0], pend_q[1], byte_i);
      2'd3:    packed_cp = pack4(pend_q[0], pend_q[1], pend_q[2], byte_i);
      default: packed_cp = single_cp(byte_i);
    endcase
  end

  // Results and next state for the byte in the input register
  always_comb begin
    bundle_o.cnt = 2'd0;
    bundle_o.cp  = '0;
    store        = 1'b0;
    pc_d         = pc_q;
    nl_d         = nl_q;
    if (eot_i) begin
      pc_d = 2'd0;
      nl_d = 2'd0;
      if (pc_q == 2'd0) begin
        bundle_o.cnt   = 2'd1;
        bundle_o.cp[0] = single_cp(byte_i);
      end else if (pc_q == nl_q) begin
        bundle_o.cnt   = 2'd1;
        bundle_o.cp[0] = packed_cp;
      end else begin
        // Truncated: lead is replaced, the rest decoded as fresh leads
        bundle_o.cp[0] = REPL_CP;
        if (pc_q == 2'd1) begin
          bundle_o.cnt   = 2'd2;
          bundle_o.cp[1] = single_cp(byte_i);
        end else if (len_p1 == 3'd1) begin
          bundle_o.cnt   = 2'd2;
          bundle_o.cp[1] = pack2(pend_q[1], byte_i);
        end else begin
          bundle_o.cnt   = 2'd3;
          bundle_o.cp[1] = single_cp(pend_q[1]);
          bundle_o.cp[2] = single_cp(byte_i);
        end
      end
    end else if (pc_q == 2'd0) begin
      if (len_c == LEN_ONE || len_c == LEN_BAD) begin
        bundle_o.cnt   = 2'd1;
        bundle_o.cp[0] = single_cp(byte_i);
      end else begin
        store = 1'b1;
        pc_d  = 2'd1;
        nl_d  = len_c[1:0];
      end
    end else if (pc_q >= nl_q) begin
      bundle_o.cnt   = 2'd1;
      bundle_o.cp[0] = packed_cp;
      pc_d           = 2'd0;
      nl_d           = 2'd0;
    end else begin
      store = 1'b1;
      pc_d  = pc_q + 2'd1;
    end
  end

  // Fill level and needed length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= 2'd0;
      nl_q <= 2'd0;
    end else if (commit_i) begin
      pc_q <= pc_d;
      nl_q <= nl_d;
    end
  end

  // Held bytes, written at the current fill level
  always_ff @(posedge clk_i) begin
    if (commit_i && store) begin
      case (pc_q)
        2'd0:    pend_q[0] <= byte_i;
        2'd1:    pend_q[1] <= byte_i;
        2'd2:    pend_q[2] <= byte_i;
        default: pend_q[2] <= byte_i;
      endcase
    end
  end

  assign status_o.pend_cnt = pc_q;
  assign status_o.need_len = nl_q;

endmodule

>>> hdl/utfd_out_buf.sv
module utfd_out_buf import utfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_req_i,
  input  bundle_t     bundle_i,
  output logic        load_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [20:0] code_point_o,
  output logic        last_of_run_o,
  output logic [1:0]  rem_o,
  output logic [1:0]  idx_o
);

  logic [2:0][20:0] cp_q;
  logic [1:0]       rem_q, rem_d;
  logic [1:0]       idx_q, idx_d;
  logic             take;

  assign out_valid_o   = (rem_q != 2'd0);
  assign take          = out_valid_o && !out_stall_i;
  assign code_point_o  = cp_q[idx_q];
  assign last_of_run_o = (rem_q == 2'd1);

  // A new bundle loads once the previous one is empty or leaves now
  assign load_o = load_req_i && ((rem_q == 2'd0) || (rem_q == 2'd1 && take));

  always_comb begin
    rem_d = rem_q;
    idx_d = idx_q;
    if (load_o) begin
      rem_d = bundle_i.cnt;
      idx_d = 2'd0;
    end else if (take) begin
      rem_d = rem_q - 2'd1;
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 2'd0;
      idx_q <= 2'd0;
    end else begin
      rem_q <= rem_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_o) begin
      cp_q <= bundle_i.cp;
    end
  end

  assign rem_o = rem_q;
  assign idx_o = idx_q;

endmodule

>>> hdl/utf8_codepoint_decoder_unit.sv
// UTF-8 to code point decoder.
// Input channel: in_valid_i / in_stall_o carry one text byte per transfer,
// with end_of_text_i set on the final byte of a text.
// Output channel: out_valid_o / out_stall_i carry one code point per
// transfer; last_of_run_o marks the final result caused by an input byte.
// A byte that only extends an open sequence gives no result.
// An accepted byte passes through the input register and, when the output
// side is free, into the result buffer, which drives the output.
// Throughput: one byte per cycle while each byte gives at most one result
// and the receiver does not stall. A byte that ends a text inside a
// sequence gives up to three results, sent one per cycle from the result
// buffer while the receiver does not stall; the input register holds the
// next byte meanwhile. When the receiver stalls, the buffer holds its
// result and the input stalls once the input register is also occupied.
// Reset clears the held sequence and both buffers, dropping any item held
// in them, and the first byte after reset starts a new text.
module utf8_codepoint_decoder_unit import utfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [20:0] code_point_o,
  output logic        last_of_run_o
);

  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_eot_q;
  logic        in_take;
  logic        load;
  bundle_t     bundle;
  dec_status_t status;
  logic [1:0]  rem;
  logic [1:0]  idx;

  assign in_stall_o = s1_valid_q && !load;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (load) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= data_byte_i;
      s1_eot_q  <= end_of_text_i;
    end
  end

  utfd_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (s1_byte_q),
    .eot_i    (s1_eot_q),
    .commit_i (load),
    .bundle_o (bundle),
    .status_o (status)
  );

  utfd_out_buf u_out_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_req_i    (s1_valid_q),
    .bundle_i      (bundle),
    .load_o        (load),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .code_point_o  (code_point_o),
    .last_of_run_o (last_of_run_o),
    .rem_o         (rem),
    .idx_o         (idx)
  );

  // Held bytes never exceed what the held lead needs
  a_pend_le_need: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.pend_cnt <= status.need_len)
    else $error("pending count above needed length");

  // Result buffer read position stays inside the bundle
  a_buf_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, idx} + {1'b0, rem}) <= 3'(MAX_RES))
    else $error("result buffer index out of range");

  // After the last result of a run leaves with nothing loaded, output idles
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_of_run_o && !out_stall_i && !load) |=> !out_valid_o)
    else $error("output valid after end of run");

endmodule
